// ----- rtl/cse_pkg.sv -----
package cse_pkg;

  localparam int unsigned NumSlots = 17;

  // slot layout of one item's text
  localparam int unsigned SlotPrefix = 0;   // " /* " then opening quote
  localparam int unsigned SlotByteA  = 5;   // held byte flushed by a new byte
  localparam int unsigned SlotByteB  = 9;   // byte flushed at end of string
  localparam int unsigned SlotSuffix = 13;  // closing quote then " */"

  localparam logic [2:0] RegZeroTerm  = 3'd0;
  localparam logic [2:0] RegForceHex  = 3'd1;
  localparam logic [2:0] RegComment   = 3'd2;
  localparam logic [2:0] RegOmitQuote = 3'd3;
  localparam logic [2:0] RegOmitNul   = 3'd4;

  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChStar   = 8'h2a;
  localparam logic [7:0] ChSlash  = 8'h2f;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChSeven  = 8'h37;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChLowA   = 8'h61;
  localparam logic [7:0] ChLowX   = 8'h78;
  localparam logic [7:0] ChTilde  = 8'h7e;

  typedef struct packed {
    logic zero_terminated;
    logic force_hex;
    logic emit_comment;
    logic omit_quotes;
    logic omit_trailing_nul;
  } cse_cfg_t;

  typedef struct packed {
    logic [7:0] pending_byte;
    logic       pending_valid;
    logic       prefix_sent;
    logic       terminated;
  } cse_state_t;

  typedef struct packed {
    logic [NumSlots-1:0][7:0] chars;
    logic [NumSlots-1:0]      en;
    logic                     fin;
    logic                     incomplete;
  } cse_plan_t;

  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [3:0]      en;
  } cse_text_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) r = ChZero + {4'd0, n};
    else           r = ChLowA + {4'd0, n - 4'd10};
    return r;
  endfunction

  function automatic logic [7:0] oct_digit(input logic [2:0] n);
    return ChZero | {5'd0, n};
  endfunction

  // escaped text of one byte, up to four characters, first in the lowest slot
  function automatic cse_text_t byte_text(input logic [7:0] c, input logic next_digit,
                                          input logic hex);
    cse_text_t t;
    t = '0;
    t.chars[0] = ChBslash;
    if (hex) begin
      t.chars[1] = ChLowX;
      t.chars[2] = hex_digit(c[7:4]);
      t.chars[3] = hex_digit(c[3:0]);
      t.en       = 4'b1111;
    end else begin
      case (c)
        ChQuote, ChBslash: begin
          t.chars[1] = c;
          t.en       = 4'b0011;
        end
        8'h0c: begin
          t.chars[1] = 8'h66;
          t.en       = 4'b0011;
        end
        8'h0a: begin
          t.chars[1] = 8'h6e;
          t.en       = 4'b0011;
        end
        8'h0d: begin
          t.chars[1] = 8'h72;
          t.en       = 4'b0011;
        end
        8'h09: begin
          t.chars[1] = 8'h74;
          t.en       = 4'b0011;
        end
        8'h0b: begin
          t.chars[1] = 8'h76;
          t.en       = 4'b0011;
        end
        default: begin
          if (c >= ChSpace && c <= ChTilde) begin
            t.chars[0] = c;
            t.en       = 4'b0001;
          end else begin
            t.chars[1] = oct_digit({1'b0, c[7:6]});
            t.chars[2] = oct_digit(c[5:3]);
            t.chars[3] = oct_digit(c[2:0]);
            t.en[0]    = 1'b1;
            t.en[1]    = next_digit || (c[7:6] != 2'd0);
            t.en[2]    = next_digit || (c[7:3] != 5'd0);
            t.en[3]    = 1'b1;
          end
        end
      endcase
    end
    return t;
  endfunction

endpackage

// ----- rtl/c_string_escaper_core.sv -----
// Channel   Dir  Beat fields (tdata low bit up / tlast / tuser low bit up)
// s_axis    in   data_byte[7:0] / is_last / has_byte, follow_nul
// m_axis    out  out_char[7:0] / end_of_text / not_complete
// cfg       in   cfg_we_i, cfg_idx_i = register index, cfg_data_i[0] = value
//
// An input transfer is expanded in the cycle it is taken into a slot buffer
// of up to 13 live characters (none to thirteen per item, up to four for an
// escaped byte); the buffer then drains one character per cycle into the
// output register while m_axis is not stalled.
// s_axis_tready rises as the last character of the buffer moves out.
// Reset clears the configuration, the string state and both valid flags.
// A stall on m_axis holds the output register and the buffer.
module c_string_escaper_core import cse_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // data_byte[7:0]
  input  logic       s_axis_tlast,   // is_last
  input  logic [1:0] s_axis_tuser,   // has_byte, follow_nul
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // out_char[7:0]
  output logic       m_axis_tlast,   // end_of_text
  output logic       m_axis_tuser,   // not_complete
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [0:0] cfg_data_i
);

  cse_cfg_t            cfg_q;
  cse_state_t          state_q;
  cse_state_t          state_d;
  cse_plan_t           plan_d;
  cse_plan_t           plan_q;
  logic [NumSlots-1:0] first;
  logic [NumSlots-1:0] rest;
  logic [7:0]          char_sel;
  logic                load_out;
  logic                s_fire;
  logic                out_valid_q;
  logic [7:0]          out_char_q;
  logic                out_last_q;
  logic                out_nc_q;

  cse_expand u_expand (
    .cfg_i       (cfg_q),
    .state_i     (state_q),
    .data_byte_i (s_axis_tdata),
    .has_byte_i  (s_axis_tuser[0]),
    .is_last_i   (s_axis_tlast),
    .follow_nul_i(s_axis_tuser[1]),
    .plan_o      (plan_d),
    .state_o     (state_d)
  );

  // pick the lowest live slot
  assign first = plan_q.en & (~plan_q.en + NumSlots'(1));
  assign rest  = plan_q.en & ~first;

  always_comb begin
    char_sel = '0;
    for (int i = 0; i < NumSlots; i++) begin
      char_sel = char_sel | (plan_q.chars[i] & {8{first[i]}});
    end
  end

  assign load_out      = (|plan_q.en) && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = (plan_q.en == '0) || (load_out && rest == '0);
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegZeroTerm:  cfg_q.zero_terminated   <= cfg_data_i[0];
        RegForceHex:  cfg_q.force_hex         <= cfg_data_i[0];
        RegComment:   cfg_q.emit_comment      <= cfg_data_i[0];
        RegOmitQuote: cfg_q.omit_quotes       <= cfg_data_i[0];
        RegOmitNul:   cfg_q.omit_trailing_nul <= cfg_data_i[0];
        default:      cfg_q <= cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      plan_q  <= '0;
    end else if (s_fire) begin
      state_q <= state_d;
      plan_q  <= plan_d;
    end else if (load_out) begin
      plan_q.en <= rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_char_q <= char_sel;
      out_last_q <= plan_q.fin && (rest == '0);
      out_nc_q   <= plan_q.fin && plan_q.incomplete && (rest == '0);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_char_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_nc_q;

  a_ready_means_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (plan_q.en != '0))
    else $error("input stalled with an empty slot buffer");

  a_no_pending_after_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(state_q.terminated && state_q.pending_valid))
    else $error("byte held after the string was terminated");

  a_swallow_after_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && state_q.terminated) |=> (plan_q.en == '0))
    else $error("characters made after the terminator");

  a_status_on_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("completion status off the final character");

endmodule

// ----- rtl/cse_expand.sv -----
module cse_expand import cse_pkg::*; (
  input  cse_cfg_t   cfg_i,
  input  cse_state_t state_i,
  input  logic [7:0] data_byte_i,
  input  logic       has_byte_i,
  input  logic       is_last_i,
  input  logic       follow_nul_i,
  output cse_plan_t  plan_o,
  output cse_state_t state_o
);

  logic       stop;
  logic       next_digit;
  logic       pv;
  logic [7:0] pb;
  cse_text_t  text_a;
  cse_text_t  text_b;

  assign next_digit = (data_byte_i >= ChZero) && (data_byte_i <= ChSeven);
  assign stop = (cfg_i.zero_terminated && data_byte_i == 8'd0) ||
                (!cfg_i.force_hex && is_last_i && cfg_i.omit_trailing_nul &&
                 data_byte_i == 8'd0);
  assign text_a = byte_text(state_i.pending_byte, next_digit, cfg_i.force_hex);
  assign text_b = byte_text(pb, 1'b0, cfg_i.force_hex);

  always_comb begin
    pv = state_i.pending_valid;
    pb = state_i.pending_byte;
    if (has_byte_i && !stop) begin
      pv = 1'b1;
      pb = data_byte_i;
    end else if (has_byte_i) begin
      pv = 1'b0;
    end
  end

  always_comb begin
    plan_o  = '0;
    state_o = state_i;

    plan_o.chars[SlotPrefix+0] = ChSpace;
    plan_o.chars[SlotPrefix+1] = ChSlash;
    plan_o.chars[SlotPrefix+2] = ChStar;
    plan_o.chars[SlotPrefix+3] = ChSpace;
    plan_o.chars[SlotPrefix+4] = ChQuote;
    for (int i = 0; i < 4; i++) begin
      plan_o.chars[SlotByteA+i] = text_a.chars[i];
      plan_o.chars[SlotByteB+i] = text_b.chars[i];
    end
    plan_o.chars[SlotSuffix+0] = ChQuote;
    plan_o.chars[SlotSuffix+1] = ChSpace;
    plan_o.chars[SlotSuffix+2] = ChStar;
    plan_o.chars[SlotSuffix+3] = ChSlash;

    if (state_i.terminated) begin
      // swallow the rest of the string
      if (is_last_i) state_o = '0;
    end else if (has_byte_i || is_last_i) begin
      if (!state_i.prefix_sent) begin
        plan_o.en[SlotPrefix +: 4] = {4{cfg_i.emit_comment}};
        plan_o.en[SlotPrefix+4]    = !cfg_i.omit_quotes;
        state_o.prefix_sent        = 1'b1;
      end
      if (has_byte_i && state_i.pending_valid) begin
        plan_o.en[SlotByteA +: 4] = text_a.en;
      end
      if (has_byte_i && stop) begin
        plan_o.fin = 1'b1;
        if (is_last_i) begin
          state_o = '0;
        end else begin
          state_o.terminated    = 1'b1;
          state_o.pending_valid = 1'b0;
        end
      end else if (is_last_i) begin
        if (pv) plan_o.en[SlotByteB +: 4] = text_b.en;
        plan_o.fin        = 1'b1;
        plan_o.incomplete = !(cfg_i.zero_terminated && follow_nul_i);
        state_o           = '0;
      end else begin
        state_o.pending_byte  = pb;
        state_o.pending_valid = pv;
      end
    end

    if (plan_o.fin) begin
      plan_o.en[SlotSuffix]        = !cfg_i.omit_quotes;
      plan_o.en[SlotSuffix+1 +: 3] = {3{cfg_i.emit_comment}};
    end
  end

endmodule
